@@ rtl/core/atrp_pkg.sv @@
// Shared types and constants for the ADTS to RTP packetizer.
// Used by the front, the command queue, the back end and the top level.
`timescale 1ns / 1ps

package atrp_pkg;

    localparam int FL_W     = 13;  // ADTS frame length width
    localparam int HDR_LEN  = 7;   // ADTS header bytes
    localparam int Q_DEPTH  = 4;
    localparam int Q_AW     = 2;

    localparam logic [7:0] RTP_BYTE0 = 8'h80;  // version 2, no padding/extension/CSRC
    localparam logic [7:0] SYNC_HI   = 8'hFF;
    localparam logic [3:0] SYNC_LO   = 4'hF;

    // Configuration register indexes
    localparam logic CFG_PAYLOAD_TYPE = 1'b0;
    localparam logic CFG_TS_STEP      = 1'b1;

    // Header byte indexes that the back end emits after the first byte
    localparam logic [3:0] IDX_LEN0 = 4'd12;
    localparam logic [3:0] IDX_LEN1 = 4'd13;

    typedef enum logic [1:0] {
        K_BYTE = 2'd0,  // forward one payload byte
        K_HDR  = 2'd1,  // emit an RTP header and length bytes
        K_ERR  = 2'd2   // emit one error result
    } t_kind;

    typedef struct packed {
        t_kind           kind;
        logic [7:0]      data;
        logic            last;
        logic [FL_W-1:0] plen;
    } t_cmd;

endpackage

@@ rtl/core/adts_to_rtp_packetizer.sv @@
// Top level of the ADTS AAC to RTP packetizer: configuration registers and wiring.
// Depends on atrp_pkg, atrp_front, atrp_queue and atrp_back.
//
//  Channel   Valid           Stall           Payload
//  -------   -------------   -------------   -------------------------------------------
//  input     i_in_valid      o_in_stall      i_in_byte
//  output    o_out_valid     i_out_stall     o_out_byte, o_packet_end, o_sync_error
//  config    i_cfg_we        (none)          i_cfg_idx, i_cfg_wdata
//
// Payload bytes pass at one transfer per cycle while no stall or header holds them.
// Each valid ADTS header expands into 13 or 14 output bytes that the back end's header
// sequencer emits one per unstalled cycle; input stalls once the four-entry queue fills.
// Reset is synchronous and active low; it clears all counters and restores the
// register defaults (payload type 97, timestamp step 6000).
// Either side may stall at any time; the queue and output register hold their data.
`timescale 1ns / 1ps

module adts_to_rtp_packetizer #(
    parameter int CHUNK = 255
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_wdata,
    // ADTS byte stream in
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_in_byte,
    // RTP byte stream out
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_packet_end,
    output logic        o_sync_error
);
    import atrp_pkg::*;

    logic [6:0]  r_payload_type;
    logic [31:0] r_ts_step;

    logic        in_accept;
    logic        f_push;
    t_cmd        f_cmd;
    logic        q_valid;
    logic        q_full;
    t_cmd        q_cmd;
    logic        b_pop;

    // The user must write the registers only while the block is idle; the block does not
    // enforce this. The back end reads them directly when it builds a header.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_payload_type <= 7'd97;
            r_ts_step      <= 32'd6000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PAYLOAD_TYPE: r_payload_type <= i_cfg_wdata[6:0];
                CFG_TS_STEP:      r_ts_step      <= i_cfg_wdata;
                default:          r_ts_step      <= r_ts_step;
            endcase
        end
    end

    // Every accepted byte produces at most one queue entry, so a free slot is all
    // the front needs to take a transfer.
    assign o_in_stall = q_full;
    assign in_accept  = i_in_valid && !q_full;

    atrp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_byte   (i_in_byte),
        .o_push   (f_push),
        .o_cmd    (f_cmd)
    );

    atrp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_cmd   (f_cmd),
        .i_pop   (b_pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_cmd   (q_cmd)
    );

    atrp_back #(
        .CHUNK (CHUNK)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_cmd        (q_cmd),
        .o_pop          (b_pop),
        .i_payload_type (r_payload_type),
        .i_ts_step      (r_ts_step),
        .o_valid        (o_out_valid),
        .i_stall        (i_out_stall),
        .o_byte         (o_out_byte),
        .o_end          (o_packet_end),
        .o_err          (o_sync_error)
    );

endmodule

@@ rtl/core/atrp_front.sv @@
// Front end: collects the ADTS header, checks it and classifies every input byte.
// Depends on atrp_pkg; pushes t_cmd entries into the command queue.
`timescale 1ns / 1ps

module atrp_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_byte,
    output logic                o_push,
    output atrp_pkg::t_cmd      o_cmd
);
    import atrp_pkg::*;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'b01,
        PH_PAYLOAD = 2'b10
    } t_phase;

    t_phase          r_phase, n_phase;
    logic [2:0]      r_hpos, n_hpos;
    logic [FL_W-1:0] r_bpos, n_bpos;
    logic [FL_W-1:0] r_plen, n_plen;
    logic [7:0]      r_hs [HDR_LEN-1];

    logic [FL_W-1:0] frame_len;
    logic [FL_W-1:0] bpos_inc;
    logic            hdr_bad;

    assign frame_len = {r_hs[3][1:0], r_hs[4], r_hs[5][7:5]};
    assign hdr_bad   = (r_hs[0] != SYNC_HI) || (r_hs[1][7:4] != SYNC_LO)
                       || (frame_len < FL_W'(HDR_LEN));
    assign bpos_inc  = r_bpos + FL_W'(1);

    always_comb begin
        n_phase = r_phase;
        n_hpos  = r_hpos;
        n_bpos  = r_bpos;
        n_plen  = r_plen;
        o_push  = 1'b0;
        o_cmd   = '0;
        if (i_accept) begin
            unique case (r_phase)
                PH_PAYLOAD: begin
                    o_push     = 1'b1;
                    o_cmd.kind = K_BYTE;
                    o_cmd.data = i_byte;
                    o_cmd.last = (bpos_inc >= r_plen);
                    if (bpos_inc >= r_plen) begin
                        n_phase = PH_HUNT;
                        n_bpos  = '0;
                    end else begin
                        n_bpos = bpos_inc;
                    end
                end
                PH_HUNT: begin
                    if (r_hpos != 3'(HDR_LEN - 1)) begin
                        n_hpos = r_hpos + 3'd1;
                    end else begin
                        n_hpos = '0;
                        o_push = 1'b1;
                        if (hdr_bad) begin
                            o_cmd.kind = K_ERR;
                        end else begin
                            o_cmd.kind = K_HDR;
                            o_cmd.plen = frame_len - FL_W'(HDR_LEN);
                            n_plen     = frame_len - FL_W'(HDR_LEN);
                            n_bpos     = '0;
                            if (frame_len != FL_W'(HDR_LEN)) begin
                                n_phase = PH_PAYLOAD;
                            end
                        end
                    end
                end
                default: begin
                    n_phase = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_hpos  <= '0;
            r_bpos  <= '0;
            r_plen  <= '0;
        end else begin
            r_phase <= n_phase;
            r_hpos  <= n_hpos;
            r_bpos  <= n_bpos;
            r_plen  <= n_plen;
        end
    end

    // Header bytes; the seventh carries nothing the block needs and is not stored.
    always_ff @(posedge i_clk) begin
        if (i_accept && (r_phase == PH_HUNT) && (r_hpos != 3'(HDR_LEN - 1))) begin
            r_hs[r_hpos] <= i_byte;
        end
    end

endmodule

@@ rtl/core/atrp_queue.sv @@
// Small command queue between the front and the back end.
// Depends on atrp_pkg for the t_cmd entry type and the depth.
`timescale 1ns / 1ps

module atrp_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  atrp_pkg::t_cmd      i_cmd,
    input  logic                i_pop,
    output logic                o_valid,
    output logic                o_full,
    output atrp_pkg::t_cmd      o_cmd
);
    import atrp_pkg::*;

    t_cmd            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp, r_rp;
    logic [Q_AW:0]   r_cnt;

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + Q_AW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + Q_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (Q_AW+1)'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - (Q_AW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

@@ rtl/core/atrp_back.sv @@
// Back end: carries out queued commands, builds RTP headers, owns the output register.
// Depends on atrp_pkg; keeps sequence number, timestamp and frame count.
`timescale 1ns / 1ps

module atrp_back #(
    parameter int CHUNK = 255
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  atrp_pkg::t_cmd      i_q_cmd,
    output logic                o_pop,
    input  logic [6:0]          i_payload_type,
    input  logic [31:0]         i_ts_step,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [7:0]          o_byte,
    output logic                o_end,
    output logic                o_err
);
    import atrp_pkg::*;

    // plen mod CHUNK via reciprocal multiply plus one correction step.
    localparam int RS    = 21;
    localparam int RM    = (1 << RS) / CHUNK;
    localparam int RM_W  = RS + 1;
    localparam int PR_W  = FL_W + RM_W;

    logic            out_free;
    logic            r_active;
    logic [3:0]      r_idx;
    logic [FL_W-1:0] r_plen;
    logic [15:0]     r_seq;
    logic [31:0]     r_ts;
    logic [31:0]     r_fc;
    logic [FL_W-1:0] r_q;
    logic [7:0]      r_mod;

    logic            r_ovalid;
    logic [7:0]      r_obyte;
    logic            r_oend;
    logic            r_oerr;

    logic [PR_W-1:0] prod;
    logic [FL_W-1:0] rem_raw;
    logic            is_long;
    logic [3:0]      last_idx;
    logic [7:0]      hdr_byte;

    assign out_free = !r_ovalid || !i_stall;
    assign o_pop    = out_free && !r_active && i_q_valid;
    assign is_long  = (r_plen > FL_W'(CHUNK));
    assign last_idx = is_long ? IDX_LEN1 : IDX_LEN0;

    assign prod    = PR_W'(r_plen) * PR_W'(RM);
    assign rem_raw = r_plen - FL_W'(r_q * FL_W'(CHUNK));

    always_ff @(posedge i_clk) begin
        r_q   <= prod[RS +: FL_W];
        r_mod <= (rem_raw >= FL_W'(CHUNK)) ? 8'(rem_raw - FL_W'(CHUNK)) : rem_raw[7:0];
    end

    always_comb begin
        unique case (r_idx)
            4'd1:    hdr_byte = {1'b0, i_payload_type};
            4'd2:    hdr_byte = r_seq[15:8];
            4'd3:    hdr_byte = r_seq[7:0];
            4'd4:    hdr_byte = r_ts[31:24];
            4'd5:    hdr_byte = r_ts[23:16];
            4'd6:    hdr_byte = r_ts[15:8];
            4'd7:    hdr_byte = r_ts[7:0];
            4'd8:    hdr_byte = r_fc[31:24];
            4'd9:    hdr_byte = r_fc[23:16];
            4'd10:   hdr_byte = r_fc[15:8];
            4'd11:   hdr_byte = r_fc[7:0];
            4'd12:   hdr_byte = is_long ? 8'(CHUNK) : r_plen[7:0];
            4'd13:   hdr_byte = r_mod;
            default: hdr_byte = RTP_BYTE0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_active <= 1'b0;
            r_idx    <= '0;
            r_seq    <= '0;
            r_ts     <= '0;
            r_fc     <= '0;
        end else if (out_free) begin
            if (r_active) begin
                r_ovalid <= 1'b1;
                r_idx    <= r_idx + 4'd1;
                if (r_idx == last_idx) begin
                    r_active <= 1'b0;
                    r_seq    <= r_seq + 16'd1;
                    r_fc     <= r_fc + 32'd1;
                end
            end else if (i_q_valid) begin
                r_ovalid <= 1'b1;
                if (i_q_cmd.kind == K_HDR) begin
                    r_active <= 1'b1;
                    r_idx    <= 4'd1;
                    r_ts     <= r_ts + i_ts_step;
                end
            end else begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && (i_q_cmd.kind == K_HDR)) begin
            r_plen <= i_q_cmd.plen;
        end
        if (out_free) begin
            if (r_active) begin
                r_obyte <= hdr_byte;
                r_oend  <= (r_idx == IDX_LEN0) && (r_plen == '0);
                r_oerr  <= 1'b0;
            end else begin
                unique case (i_q_cmd.kind)
                    K_BYTE: begin
                        r_obyte <= i_q_cmd.data;
                        r_oend  <= i_q_cmd.last;
                        r_oerr  <= 1'b0;
                    end
                    K_HDR: begin
                        r_obyte <= RTP_BYTE0;
                        r_oend  <= 1'b0;
                        r_oerr  <= 1'b0;
                    end
                    default: begin
                        r_obyte <= 8'd0;
                        r_oend  <= 1'b0;
                        r_oerr  <= 1'b1;
                    end
                endcase
            end
        end
    end

    assign o_valid = r_ovalid;
    assign o_byte  = r_obyte;
    assign o_end   = r_oend;
    assign o_err   = r_oerr;

endmodule
